// ----- hw/rtl/sparse_table_range_min_query_unit_defines.svh -----
// assertion macros for the sparse table range minimum unit
// used by the top level only; expects clk and rst in scope
`ifndef SPARSE_TABLE_RANGE_MIN_QUERY_UNIT_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_QUERY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define STRMQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define STRMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STRMQ_ASSERT_SAME(lbl, ante, cons, msg)
`define STRMQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/strmq_pkg.sv -----
// shared types and constants for the sparse table range minimum unit
// no dependencies
`default_nettype none

package strmq_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int VALUE_BITS_DEF   = 32;

  localparam int OP_W     = 2;
  localparam int POS_W    = 10;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;
  localparam int SPAN_W   = POS_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    store_we;
    logic    capture;
    logic    build_init;
    logic    set_build_addr;
    logic    set_query_addr;
    logic    rd_tab;
    logic    rd_el;
    logic    tab_we;
    logic    next_entry;
    logic    next_level;
    logic    out_load;
    status_t out_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_in_range;
    logic in_bad_range;
    logic len_ge2;
    logic entry_more;
    logic level_more;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/strmq_if.sv -----
// valid/ready channel interfaces for input items and result items
// depends on strmq_pkg
`default_nettype none

interface strmq_in_if #(
  parameter int VALUE_BITS = strmq_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [strmq_pkg::OP_W-1:0]   op;
  logic [strmq_pkg::POS_W-1:0]  position;
  logic signed [VALUE_BITS-1:0] value;
  logic [strmq_pkg::POS_W-1:0]  left;
  logic [strmq_pkg::POS_W-1:0]  right;

  modport source (output valid, op, position, value, left, right, input ready);
  modport sink   (input valid, op, position, value, left, right, output ready);
endinterface

interface strmq_out_if #(
  parameter int VALUE_BITS = strmq_pkg::VALUE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [strmq_pkg::POS_W-1:0]    min_position;
  logic signed [VALUE_BITS-1:0]   min_value;
  logic [strmq_pkg::STATUS_W-1:0] status;

  modport source (output valid, min_position, min_value, status, input ready);
  modport sink   (input valid, min_position, min_value, status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/strmq_ctrl.sv -----
// controller: op decode, build sequencing, query steps, result handshake
// depends on strmq_pkg
`default_nettype none

module strmq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       in_valid,
  input  logic [strmq_pkg::OP_W-1:0] in_op,
  output logic                       in_ready,
  input  logic                       out_ready,
  output logic                       out_valid,
  input  strmq_pkg::dp_stat_t        stat,
  output strmq_pkg::dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_QLVL,
    S_RDTAB,
    S_RDEL,
    S_CMP,
    S_QOUT
  } state_t;

  state_t              state, state_next;
  logic                built, built_next;
  logic                building, building_next;
  strmq_pkg::status_t  q_status, q_status_next;
  logic                out_valid_next;
  logic                accept;
  logic                out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.out_status = strmq_pkg::ST_OK;
    state_next     = state;
    built_next     = built;
    building_next  = building;
    q_status_next  = q_status;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            strmq_pkg::OP_LOAD: begin
              if (stat.pos_in_range) begin
                cmd.store_we = 1'b1;
                built_next   = 1'b0;
              end
            end
            strmq_pkg::OP_BUILD: begin
              if (stat.len_ge2) begin
                cmd.build_init = 1'b1;
                building_next  = 1'b1;
                state_next     = S_SET;
              end else begin
                // single element: only level zero, nothing to store
                built_next = 1'b1;
              end
            end
            strmq_pkg::OP_QUERY: begin
              cmd.capture   = 1'b1;
              building_next = 1'b0;
              if (!built) begin
                q_status_next = strmq_pkg::ST_NOT_BUILT;
                state_next    = S_QOUT;
              end else if (stat.in_bad_range) begin
                q_status_next = strmq_pkg::ST_BAD_RANGE;
                state_next    = S_QOUT;
              end else begin
                q_status_next = strmq_pkg::ST_OK;
                state_next    = S_QLVL;
              end
            end
            default: ;
          endcase
        end
        if (cfg_we) begin
          built_next = 1'b0;
        end
      end
      S_SET: begin
        cmd.set_build_addr = 1'b1;
        state_next         = S_RDTAB;
      end
      S_QLVL: begin
        cmd.set_query_addr = 1'b1;
        state_next         = S_RDTAB;
      end
      S_RDTAB: begin
        cmd.rd_tab = 1'b1;
        state_next = S_RDEL;
      end
      S_RDEL: begin
        cmd.rd_el  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (building) begin
          cmd.tab_we = 1'b1;
          if (stat.entry_more) begin
            cmd.next_entry = 1'b1;
            state_next     = S_SET;
          end else if (stat.level_more) begin
            cmd.next_level = 1'b1;
            state_next     = S_SET;
          end else begin
            built_next = 1'b1;
            state_next = S_IDLE;
          end
        end else if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = q_status;
          state_next     = S_IDLE;
        end
      end
      S_QOUT: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = q_status;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      built     <= 1'b0;
      building  <= 1'b0;
      q_status  <= strmq_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      built     <= built_next;
      building  <= building_next;
      q_status  <= q_status_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/strmq_dp.sv -----
// datapath: element store, sparse table memory, counters, compare, result regs
// depends on strmq_pkg; driven by strmq_ctrl commands
`default_nettype none

module strmq_dp #(
  parameter int MAX_ELEMENTS = strmq_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = strmq_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [strmq_pkg::LEN_W-1:0]    cfg_data,
  input  logic [strmq_pkg::POS_W-1:0]    in_position,
  input  logic signed [VALUE_BITS-1:0]   in_value,
  input  logic [strmq_pkg::POS_W-1:0]    in_left,
  input  logic [strmq_pkg::POS_W-1:0]    in_right,
  input  strmq_pkg::dp_cmd_t             cmd,
  output strmq_pkg::dp_stat_t            stat,
  output logic [strmq_pkg::POS_W-1:0]    min_position,
  output logic signed [VALUE_BITS-1:0]   min_value,
  output logic [strmq_pkg::STATUS_W-1:0] status
);

  localparam int AW        = $clog2(MAX_ELEMENTS);
  localparam int LW        = $clog2(MAX_ELEMENTS + 1);
  localparam int LEVELS    = AW + 1;
  localparam int KW        = $clog2(LEVELS + 1);
  localparam int TAB_DEPTH = LEVELS * MAX_ELEMENTS;
  localparam int TW        = $clog2(TAB_DEPTH);
  localparam int SW        = AW + 2;
  localparam int SPW       = strmq_pkg::SPAN_W;

  logic [VALUE_BITS-1:0] elem_mem [MAX_ELEMENTS];
  logic [AW-1:0]         tab_mem  [TAB_DEPTH];

  logic [LW-1:0]  len_reg;
  logic [LW-1:0]  cfg_len;

  logic [KW-1:0]  bk;
  logic [AW-1:0]  bj;
  logic [SW-1:0]  span_w;
  logic [SW-1:0]  half_w;

  logic [strmq_pkg::POS_W-1:0] q_left, q_right;
  logic [SPW-1:0]              q_span;
  logic [KW-1:0]               q_k;
  logic [SPW-1:0]              q_jb;

  logic [KW-1:0]  rk;
  logic [AW-1:0]  ra, rb;
  logic [AW-1:0]  ta, tb;
  logic [AW-1:0]  pa, pb;
  logic [AW-1:0]  pa_r, pb_r;
  logic signed [VALUE_BITS-1:0] va, vb;

  logic                         left_wins;
  logic [AW-1:0]                win_pos;
  logic signed [VALUE_BITS-1:0] win_val;
  logic                         out_ok;

  // length register, saturated into 1..MAX_ELEMENTS
  always_comb begin
    if (cfg_data == '0) begin
      cfg_len = LW'(1);
    end else if (32'(cfg_data) > 32'(MAX_ELEMENTS)) begin
      cfg_len = LW'(MAX_ELEMENTS);
    end else begin
      cfg_len = LW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= LW'(MAX_ELEMENTS);
    end else if (cfg_we) begin
      len_reg <= cfg_len;
    end
  end

  // build level and entry counters
  assign span_w = SW'(1) << bk;
  assign half_w = span_w >> 1;

  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      bk <= KW'(1);
      bj <= '0;
    end else if (cmd.next_entry) begin
      bj <= bj + AW'(1);
    end else if (cmd.next_level) begin
      bk <= bk + KW'(1);
      bj <= '0;
    end
  end

  assign stat.pos_in_range = 32'(in_position) < 32'(MAX_ELEMENTS);
  assign stat.in_bad_range = (in_left > in_right) || (32'(in_right) >= 32'(len_reg));
  assign stat.len_ge2      = len_reg >= LW'(2);
  assign stat.entry_more   = (SW'(bj) + SW'(1) + span_w) <= SW'(len_reg);
  assign stat.level_more   = (span_w << 1) <= SW'(len_reg);

  // query capture; level is the top set bit of the span
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_left  <= in_left;
      q_right <= in_right;
      q_span  <= SPW'(in_right) - SPW'(in_left) + SPW'(1);
    end
  end

  always_comb begin
    q_k = '0;
    for (int i = 0; i < SPW; i++) begin
      if (q_span[i]) begin
        q_k = KW'(i);
      end
    end
  end

  assign q_jb = SPW'(q_right) + SPW'(1) - (SPW'(1) << q_k);

  // pair of table addresses for the next merge
  always_ff @(posedge clk) begin
    if (cmd.set_build_addr) begin
      rk <= bk - KW'(1);
      ra <= bj;
      rb <= bj + AW'(half_w);
    end else if (cmd.set_query_addr) begin
      rk <= q_k;
      ra <= AW'(q_left);
      rb <= AW'(q_jb);
    end
  end

  // sparse table memory, level zero is the identity and never stored
  always_ff @(posedge clk) begin
    if (cmd.tab_we) begin
      tab_mem[TW'(bk) * TW'(MAX_ELEMENTS) + TW'(bj)] <= win_pos;
    end
    if (cmd.rd_tab) begin
      ta <= tab_mem[TW'(rk) * TW'(MAX_ELEMENTS) + TW'(ra)];
      tb <= tab_mem[TW'(rk) * TW'(MAX_ELEMENTS) + TW'(rb)];
    end
  end

  assign pa = (rk == '0) ? ra : ta;
  assign pb = (rk == '0) ? rb : tb;

  // element store
  always_ff @(posedge clk) begin
    if (cmd.store_we) begin
      elem_mem[AW'(in_position)] <= in_value;
    end
    if (cmd.rd_el) begin
      va   <= elem_mem[pa];
      vb   <= elem_mem[pb];
      pa_r <= pa;
      pb_r <= pb;
    end
  end

  // left block wins only when strictly smaller
  assign left_wins = va < vb;
  assign win_pos   = left_wins ? pa_r : pb_r;
  assign win_val   = left_wins ? va : vb;
  assign out_ok    = cmd.out_status == strmq_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= cmd.out_status;
      min_position <= out_ok ? strmq_pkg::POS_W'(win_pos) : '0;
      min_value    <= out_ok ? win_val : '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sparse_table_range_min_query_unit.sv -----
// sparse table range minimum unit. one item in flight at a time.
// load: element written as it is accepted. query: states QLVL, RDTAB, RDEL, CMP; result
// and next item once the output is free. query before build or with a bad range: QOUT only.
// build: states SET, RDTAB, RDEL, CMP per stored entry (one merge through the table and
// element memory read ports), sum over levels k>=1 of (length_in_use - 2^k + 1) entries.
// reset: control cleared, length_in_use = MAX_ELEMENTS, table not built, memories kept.
`default_nettype none
`include "sparse_table_range_min_query_unit_defines.svh"

module sparse_table_range_min_query_unit #(
  parameter int MAX_ELEMENTS = strmq_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = strmq_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [strmq_pkg::LEN_W-1:0] cfg_data,
  strmq_in_if.sink                    in_ch,
  strmq_out_if.source                 out_ch
);

  strmq_pkg::dp_cmd_t  cmd;
  strmq_pkg::dp_stat_t stat;

  strmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  strmq_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_position  (in_ch.position),
    .in_value     (in_ch.value),
    .in_left      (in_ch.left),
    .in_right     (in_ch.right),
    .cmd          (cmd),
    .stat         (stat),
    .min_position (out_ch.min_position),
    .min_value    (out_ch.min_value),
    .status       (out_ch.status)
  );

  `STRMQ_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_ch.valid || out_ch.ready, "result overwritten before taken")
  `STRMQ_ASSERT_NEXT(a_query_busy, in_ch.valid && in_ch.ready && in_ch.op == strmq_pkg::OP_QUERY, !in_ch.ready, "item accepted during query")
  `STRMQ_ASSERT_SAME(a_build_busy, cmd.tab_we, !in_ch.ready && !cmd.out_load, "table write outside build")

endmodule

`default_nettype wire
